[rtl/glb_pkg.sv]
// Package for the grid line bitboard: board geometry, field widths,
// command classes, the queued command type and the line helper functions.
// Depends on nothing; every rtl file refers to it by scoped names.
package glb_pkg;

    // Board geometry
    localparam int BOARD_SIZE    = 15;
    localparam int WINDOW_RADIUS = 4;
    localparam int DIAG_COUNT    = 2 * BOARD_SIZE - 1;
    localparam int CELL_W        = 2;
    localparam int LINE_W        = CELL_W * BOARD_SIZE;
    localparam int WIN_W         = CELL_W * (2 * WINDOW_RADIUS + 1);
    localparam int PAD_W         = CELL_W * WINDOW_RADIUS;
    localparam int EXT_W         = LINE_W + 2 * PAD_W;
    localparam int POS_W         = $clog2(BOARD_SIZE);
    localparam int DIAG_W        = $clog2(DIAG_COUNT);

    // Port field widths
    localparam int FUNC_W  = 2;
    localparam int COORD_W = 4;

    // Function codes on the input
    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FN_SET   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

    // Off-board cell code, refused on set
    localparam logic [CELL_W-1:0] CODE_OFF = 2'd0;

    // Command classes handed from front to back
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] K_ZERO  = 3'd0;
    localparam logic [KIND_W-1:0] K_CLEAR = 3'd1;
    localparam logic [KIND_W-1:0] K_WRITE = 3'd2;
    localparam logic [KIND_W-1:0] K_READ  = 3'd3;
    localparam logic [KIND_W-1:0] K_ERROR = 3'd4;

    // Command queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  pc;    // cell position in row, diagonal and anti lines
        logic [POS_W-1:0]  pr;    // cell position in column line
        logic [DIAG_W-1:0] diag;
        logic [DIAG_W-1:0] anti;
        logic [CELL_W-1:0] code;
    } t_cmd;

    localparam logic [LINE_W-1:0] LINE_ONES = {LINE_W{1'b1}};

    // Reset image of a main diagonal: board cells 3, padding 0
    function automatic logic [LINE_W-1:0] diag_init(input int idx);
        logic [LINE_W-1:0] v;
        int                r;
        v = '0;
        for (int p = 0; p < BOARD_SIZE; p++) begin
            r = idx - (BOARD_SIZE - 1 - p);
            if (r >= 0 && r < BOARD_SIZE) v[CELL_W*p +: CELL_W] = '1;
        end
        return v;
    endfunction

    // Reset image of an anti-diagonal
    function automatic logic [LINE_W-1:0] anti_init(input int idx);
        logic [LINE_W-1:0] v;
        int                r;
        v = '0;
        for (int p = 0; p < BOARD_SIZE; p++) begin
            r = idx - p;
            if (r >= 0 && r < BOARD_SIZE) v[CELL_W*p +: CELL_W] = '1;
        end
        return v;
    endfunction

    // Cell at a line position
    function automatic logic [CELL_W-1:0] cell_at(input logic [LINE_W-1:0] line,
                                                  input logic [POS_W-1:0]  pos);
        return CELL_W'(line >> {pos, 1'b0});
    endfunction

    // Line with one cell replaced
    function automatic logic [LINE_W-1:0] put_cell(input logic [LINE_W-1:0] line,
                                                   input logic [POS_W-1:0]  pos,
                                                   input logic [CELL_W-1:0] code);
        logic [LINE_W-1:0] mask;
        mask = LINE_W'({CELL_W{1'b1}}) << {pos, 1'b0};
        return (line & ~mask) | (LINE_W'(code) << {pos, 1'b0});
    endfunction

    // Window centred on a position; off-line slots read 0 via zero padding
    function automatic logic [WIN_W-1:0] window_of(input logic [LINE_W-1:0] line,
                                                   input logic [POS_W-1:0]  pos);
        logic [EXT_W-1:0] ext;
        ext = {{PAD_W{1'b0}}, line, {PAD_W{1'b0}}};
        return WIN_W'(ext >> {pos, 1'b0});
    endfunction

endpackage

[rtl/glb_front.sv]
// Front end: takes a transfer on start and sorts it into a queued command
// with all line indices and positions worked out. Depends on glb_pkg.
module glb_front (
    input  logic                          start,
    input  logic                          busy,
    input  logic [glb_pkg::FUNC_W-1:0]    i_func,
    input  logic [glb_pkg::COORD_W-1:0]   i_row,
    input  logic [glb_pkg::COORD_W-1:0]   i_col,
    input  logic [glb_pkg::CELL_W-1:0]    i_cell_code,
    output logic                          o_push,
    output glb_pkg::t_cmd                 o_cmd
);

    logic                         on_board;
    logic [glb_pkg::POS_W-1:0]    pc;
    logic [glb_pkg::POS_W-1:0]    pr;

    assign o_push   = start && !busy;
    assign on_board = (i_row < glb_pkg::COORD_W'(glb_pkg::BOARD_SIZE))
                   && (i_col < glb_pkg::COORD_W'(glb_pkg::BOARD_SIZE));

    // Positions within the lines, first column in the high bits
    assign pc = glb_pkg::POS_W'(glb_pkg::BOARD_SIZE - 1) - glb_pkg::POS_W'(i_col);
    assign pr = glb_pkg::POS_W'(glb_pkg::BOARD_SIZE - 1) - glb_pkg::POS_W'(i_row);

    // Classify
    always_comb begin
        o_cmd      = '0;
        o_cmd.row  = glb_pkg::POS_W'(i_row);
        o_cmd.col  = glb_pkg::POS_W'(i_col);
        o_cmd.pc   = pc;
        o_cmd.pr   = pr;
        o_cmd.diag = glb_pkg::DIAG_W'(i_row) + glb_pkg::DIAG_W'(i_col);
        o_cmd.anti = glb_pkg::DIAG_W'(pc) + glb_pkg::DIAG_W'(i_row);
        o_cmd.code = i_cell_code;
        case (i_func)
            glb_pkg::FN_CLEAR: begin
                o_cmd.kind = glb_pkg::K_CLEAR;
            end
            glb_pkg::FN_SET: begin
                if (i_cell_code == glb_pkg::CODE_OFF) o_cmd.kind = glb_pkg::K_ERROR;
                else if (on_board)                    o_cmd.kind = glb_pkg::K_WRITE;
                else                                  o_cmd.kind = glb_pkg::K_ZERO;
            end
            glb_pkg::FN_READ: begin
                o_cmd.kind = on_board ? glb_pkg::K_READ : glb_pkg::K_ZERO;
            end
            default: begin
                o_cmd.kind = glb_pkg::K_ZERO;
            end
        endcase
    end

endmodule

[rtl/glb_cmd_fifo.sv]
// Short command queue between front and back ends.
// Depends on glb_pkg for the command type and depth.
module glb_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  glb_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output glb_pkg::t_cmd  o_cmd
);

    glb_pkg::t_cmd               r_q [glb_pkg::QUEUE_DEPTH];
    logic [glb_pkg::QPTR_W-1:0]  r_wr;
    logic [glb_pkg::QPTR_W-1:0]  r_rd;
    logic [glb_pkg::QCNT_W-1:0]  r_cnt;
    logic                        do_pop;

    assign o_full  = (r_cnt == glb_pkg::QCNT_W'(glb_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rd];
    assign do_pop  = i_pop && o_valid;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wr] <= i_cmd;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == glb_pkg::QPTR_W'(glb_pkg::QUEUE_DEPTH - 1))
                                ? '0 : r_wr + 1'b1;
            if (do_pop) r_rd <= (r_rd == glb_pkg::QPTR_W'(glb_pkg::QUEUE_DEPTH - 1))
                                ? '0 : r_rd + 1'b1;
            if (i_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

[rtl/glb_back.sv]
// Back end: holds the four line stores and carries out clear, write and
// read commands, one per cycle, into registered result outputs. Depends on glb_pkg.
module glb_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  glb_pkg::t_cmd                 i_cmd,
    output logic                          o_strobe,
    output logic [glb_pkg::CELL_W-1:0]    o_cell_value,
    output logic [glb_pkg::LINE_W-1:0]    o_row_line,
    output logic [glb_pkg::LINE_W-1:0]    o_col_line,
    output logic [glb_pkg::LINE_W-1:0]    o_diag_line,
    output logic [glb_pkg::LINE_W-1:0]    o_anti_line,
    output logic [glb_pkg::WIN_W-1:0]     o_row_window,
    output logic [glb_pkg::WIN_W-1:0]     o_col_window,
    output logic [glb_pkg::WIN_W-1:0]     o_diag_window,
    output logic [glb_pkg::WIN_W-1:0]     o_anti_window,
    output logic                          o_error
);

    logic [glb_pkg::LINE_W-1:0] r_row  [glb_pkg::BOARD_SIZE];
    logic [glb_pkg::LINE_W-1:0] r_col  [glb_pkg::BOARD_SIZE];
    logic [glb_pkg::LINE_W-1:0] r_diag [glb_pkg::DIAG_COUNT];
    logic [glb_pkg::LINE_W-1:0] r_anti [glb_pkg::DIAG_COUNT];

    logic                       r_strobe;
    logic [glb_pkg::CELL_W-1:0] r_cell;
    logic [glb_pkg::LINE_W-1:0] r_row_line, r_col_line, r_diag_line, r_anti_line;
    logic [glb_pkg::WIN_W-1:0]  r_row_win, r_col_win, r_diag_win, r_anti_win;
    logic                       r_error;

    logic [glb_pkg::LINE_W-1:0] n_row_line, n_col_line, n_diag_line, n_anti_line;
    logic                       do_clear, do_write, do_read;

    assign do_clear = i_valid && (i_cmd.kind == glb_pkg::K_CLEAR);
    assign do_write = i_valid && (i_cmd.kind == glb_pkg::K_WRITE);
    assign do_read  = i_valid && (i_cmd.kind == glb_pkg::K_READ);

    // Lines through the addressed cell (indices are on board for write and read)
    assign n_row_line  = r_row[i_cmd.row];
    assign n_col_line  = r_col[i_cmd.col];
    assign n_diag_line = r_diag[i_cmd.diag];
    assign n_anti_line = r_anti[i_cmd.anti];

    // Row and column stores
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < glb_pkg::BOARD_SIZE; i++) begin
            if (!i_rst_n || do_clear) begin
                r_row[i] <= glb_pkg::LINE_ONES;
                r_col[i] <= glb_pkg::LINE_ONES;
            end else if (do_write) begin
                if (i_cmd.row == glb_pkg::POS_W'(i))
                    r_row[i] <= glb_pkg::put_cell(r_row[i], i_cmd.pc, i_cmd.code);
                if (i_cmd.col == glb_pkg::POS_W'(i))
                    r_col[i] <= glb_pkg::put_cell(r_col[i], i_cmd.pr, i_cmd.code);
            end
        end
    end

    // Diagonal stores, padding kept at zero
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < glb_pkg::DIAG_COUNT; i++) begin
            if (!i_rst_n || do_clear) begin
                r_diag[i] <= glb_pkg::diag_init(i);
                r_anti[i] <= glb_pkg::anti_init(i);
            end else if (do_write) begin
                if (i_cmd.diag == glb_pkg::DIAG_W'(i))
                    r_diag[i] <= glb_pkg::put_cell(r_diag[i], i_cmd.pc, i_cmd.code);
                if (i_cmd.anti == glb_pkg::DIAG_W'(i))
                    r_anti[i] <= glb_pkg::put_cell(r_anti[i], i_cmd.pc, i_cmd.code);
            end
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_strobe <= 1'b0;
        else          r_strobe <= i_valid;
    end

    // Result payload: zero except on read, error flag on refused set
    always_ff @(posedge i_clk) begin
        if (do_read) begin
            r_cell      <= glb_pkg::cell_at(n_row_line, i_cmd.pc);
            r_row_line  <= n_row_line;
            r_col_line  <= n_col_line;
            r_diag_line <= n_diag_line;
            r_anti_line <= n_anti_line;
            r_row_win   <= glb_pkg::window_of(n_row_line, i_cmd.pc);
            r_col_win   <= glb_pkg::window_of(n_col_line, i_cmd.pr);
            r_diag_win  <= glb_pkg::window_of(n_diag_line, i_cmd.pc);
            r_anti_win  <= glb_pkg::window_of(n_anti_line, i_cmd.pc);
        end else begin
            r_cell      <= '0;
            r_row_line  <= '0;
            r_col_line  <= '0;
            r_diag_line <= '0;
            r_anti_line <= '0;
            r_row_win   <= '0;
            r_col_win   <= '0;
            r_diag_win  <= '0;
            r_anti_win  <= '0;
        end
        r_error <= (i_cmd.kind == glb_pkg::K_ERROR);
    end

    assign o_strobe      = r_strobe;
    assign o_cell_value  = r_cell;
    assign o_row_line    = r_row_line;
    assign o_col_line    = r_col_line;
    assign o_diag_line   = r_diag_line;
    assign o_anti_line   = r_anti_line;
    assign o_row_window  = r_row_win;
    assign o_col_window  = r_col_win;
    assign o_diag_window = r_diag_win;
    assign o_anti_window = r_anti_win;
    assign o_error       = r_error;

endmodule

[rtl/grid_line_bitboard_top.sv]
// Grid line bitboard: 15x15 board of 2-bit cells kept as row, column and both diagonal lines.
// A start transfer passes the queue stage, then the execute stage, to the result strobe.
// Throughput: one command per cycle; the back end drains one queue entry every cycle.
// busy stays low: the queue is popped every cycle, so it never holds more than one entry.
// Reset (synchronous, active low) empties the queue and loads the cleared board.
// Depends on glb_pkg, glb_front, glb_cmd_fifo and glb_back.
module grid_line_bitboard_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [glb_pkg::FUNC_W-1:0]    i_func,
    input  logic [glb_pkg::COORD_W-1:0]   i_row,
    input  logic [glb_pkg::COORD_W-1:0]   i_col,
    input  logic [glb_pkg::CELL_W-1:0]    i_cell_code,
    output logic                          o_strobe,
    output logic [glb_pkg::CELL_W-1:0]    o_cell_value,
    output logic [glb_pkg::LINE_W-1:0]    o_row_line,
    output logic [glb_pkg::LINE_W-1:0]    o_col_line,
    output logic [glb_pkg::LINE_W-1:0]    o_diag_line,
    output logic [glb_pkg::LINE_W-1:0]    o_anti_line,
    output logic [glb_pkg::WIN_W-1:0]     o_row_window,
    output logic [glb_pkg::WIN_W-1:0]     o_col_window,
    output logic [glb_pkg::WIN_W-1:0]     o_diag_window,
    output logic [glb_pkg::WIN_W-1:0]     o_anti_window,
    output logic                          o_error
);

    logic          push;
    glb_pkg::t_cmd front_cmd;
    logic          q_valid;
    glb_pkg::t_cmd q_cmd;

    // Accept and classify
    glb_front u_front (
        .start       (start),
        .busy        (busy),
        .i_func      (i_func),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_cell_code (i_cell_code),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    // Command queue; back end is always ready
    glb_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (1'b1),
        .o_full  (busy),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Execute
    glb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_cmd         (q_cmd),
        .o_strobe      (o_strobe),
        .o_cell_value  (o_cell_value),
        .o_row_line    (o_row_line),
        .o_col_line    (o_col_line),
        .o_diag_line   (o_diag_line),
        .o_anti_line   (o_anti_line),
        .o_row_window  (o_row_window),
        .o_col_window  (o_col_window),
        .o_diag_window (o_diag_window),
        .o_anti_window (o_anti_window),
        .o_error       (o_error)
    );

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for grid_line_bitboard_top: clear, set and read commands.
// Keeps its own board of cells and rebuilds every line and window from it per read.
// Depends on glb_pkg and the grid_line_bitboard_top RTL.
module tb;

    // Function code with no operation behind it
    localparam logic [glb_pkg::FUNC_W-1:0] FN_NONE   = 2'd3;
    // Code every board cell holds after a clear
    localparam logic [glb_pkg::CELL_W-1:0] CODE_FULL = 2'd3;

    typedef struct packed {
        logic [glb_pkg::CELL_W-1:0] cell_value;
        logic [glb_pkg::LINE_W-1:0] row_line;
        logic [glb_pkg::LINE_W-1:0] col_line;
        logic [glb_pkg::LINE_W-1:0] diag_line;
        logic [glb_pkg::LINE_W-1:0] anti_line;
        logic [glb_pkg::WIN_W-1:0]  row_window;
        logic [glb_pkg::WIN_W-1:0]  col_window;
        logic [glb_pkg::WIN_W-1:0]  diag_window;
        logic [glb_pkg::WIN_W-1:0]  anti_window;
        logic                       error;
    } t_board_result;

    // Board model and queue of expected result transfers
    class t_board_scoreboard;
        logic [glb_pkg::CELL_W-1:0] cells [glb_pkg::BOARD_SIZE][glb_pkg::BOARD_SIZE];
        t_board_result              expected_q[$];
        int                         mismatches;

        function new();
            mismatches = 0;
            wipe();
        endfunction

        function void wipe();
            for (int r = 0; r < glb_pkg::BOARD_SIZE; r++)
                for (int c = 0; c < glb_pkg::BOARD_SIZE; c++)
                    cells[r][c] = CODE_FULL;
        endfunction

        // Column c sits at position BOARD_SIZE-1-c of its row line
        function logic [glb_pkg::LINE_W-1:0] row_image(int r);
            logic [glb_pkg::LINE_W-1:0] v;
            v = '0;
            for (int c = 0; c < glb_pkg::BOARD_SIZE; c++)
                v[glb_pkg::CELL_W*(glb_pkg::BOARD_SIZE-1-c) +: glb_pkg::CELL_W] = cells[r][c];
            return v;
        endfunction

        function logic [glb_pkg::LINE_W-1:0] col_image(int c);
            logic [glb_pkg::LINE_W-1:0] v;
            v = '0;
            for (int r = 0; r < glb_pkg::BOARD_SIZE; r++)
                v[glb_pkg::CELL_W*(glb_pkg::BOARD_SIZE-1-r) +: glb_pkg::CELL_W] = cells[r][c];
            return v;
        endfunction

        // Main diagonal d holds the cells with row + col = d
        function logic [glb_pkg::LINE_W-1:0] diag_image(int d);
            logic [glb_pkg::LINE_W-1:0] v;
            int                         r;
            v = '0;
            for (int p = 0; p < glb_pkg::BOARD_SIZE; p++) begin
                r = d - (glb_pkg::BOARD_SIZE - 1 - p);
                if (r >= 0 && r < glb_pkg::BOARD_SIZE)
                    v[glb_pkg::CELL_W*p +: glb_pkg::CELL_W] =
                        cells[r][glb_pkg::BOARD_SIZE-1-p];
            end
            return v;
        endfunction

        // Anti-diagonal a holds the cells with (BOARD_SIZE-1-col) + row = a
        function logic [glb_pkg::LINE_W-1:0] anti_image(int a);
            logic [glb_pkg::LINE_W-1:0] v;
            int                         r;
            v = '0;
            for (int p = 0; p < glb_pkg::BOARD_SIZE; p++) begin
                r = a - p;
                if (r >= 0 && r < glb_pkg::BOARD_SIZE)
                    v[glb_pkg::CELL_W*p +: glb_pkg::CELL_W] =
                        cells[r][glb_pkg::BOARD_SIZE-1-p];
            end
            return v;
        endfunction

        // Slot k holds line position pos-WINDOW_RADIUS+k; off the line reads 0
        function logic [glb_pkg::WIN_W-1:0] window_around(logic [glb_pkg::LINE_W-1:0] line,
                                                          int pos);
            logic [glb_pkg::WIN_W-1:0] w;
            int                        q;
            w = '0;
            for (int k = 0; k <= 2 * glb_pkg::WINDOW_RADIUS; k++) begin
                q = pos - glb_pkg::WINDOW_RADIUS + k;
                if (q >= 0 && q < glb_pkg::BOARD_SIZE)
                    w[glb_pkg::CELL_W*k +: glb_pkg::CELL_W] =
                        line[glb_pkg::CELL_W*q +: glb_pkg::CELL_W];
            end
            return w;
        endfunction

        // Accepted command: update the board and queue the result it causes
        function void note_command(logic [glb_pkg::FUNC_W-1:0] f,
                                   logic [glb_pkg::COORD_W-1:0] row,
                                   logic [glb_pkg::COORD_W-1:0] col,
                                   logic [glb_pkg::CELL_W-1:0] code);
            t_board_result              res;
            logic [glb_pkg::LINE_W-1:0] rl, cl, dl, al;
            int                         r, c, pc, pr;
            bit                         on_board;
            res      = '0;
            r        = int'(row);
            c        = int'(col);
            on_board = (r < glb_pkg::BOARD_SIZE) && (c < glb_pkg::BOARD_SIZE);
            pc       = glb_pkg::BOARD_SIZE - 1 - c;
            pr       = glb_pkg::BOARD_SIZE - 1 - r;
            case (f)
                glb_pkg::FN_CLEAR: wipe();
                glb_pkg::FN_SET: begin
                    if (code == glb_pkg::CODE_OFF)
                        res.error = 1'b1;
                    else if (on_board)
                        cells[r][c] = code;
                end
                glb_pkg::FN_READ: begin
                    if (on_board) begin
                        rl = row_image(r);
                        cl = col_image(c);
                        dl = diag_image(r + c);
                        al = anti_image(pc + r);
                        res.cell_value  = cells[r][c];
                        res.row_line    = rl;
                        res.col_line    = cl;
                        res.diag_line   = dl;
                        res.anti_line   = al;
                        res.row_window  = window_around(rl, pc);
                        res.col_window  = window_around(cl, pr);
                        res.diag_window = window_around(dl, pc);
                        res.anti_window = window_around(al, pc);
                    end
                end
                default: ;
            endcase
            expected_q.push_back(res);
        endfunction

        function void compare_field(string field, logic [glb_pkg::LINE_W-1:0] want,
                                    logic [glb_pkg::LINE_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                mismatches++;
            end
        endfunction

        // Result transfer: compare with the oldest expectation
        function void check_result(t_board_result got);
            t_board_result want;
            if (expected_q.size() == 0) begin
                $error("result strobe with no command outstanding");
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("cell_value",  glb_pkg::LINE_W'(want.cell_value),
                          glb_pkg::LINE_W'(got.cell_value));
            compare_field("row_line",    want.row_line,    got.row_line);
            compare_field("col_line",    want.col_line,    got.col_line);
            compare_field("diag_line",   want.diag_line,   got.diag_line);
            compare_field("anti_line",   want.anti_line,   got.anti_line);
            compare_field("row_window",  glb_pkg::LINE_W'(want.row_window),
                          glb_pkg::LINE_W'(got.row_window));
            compare_field("col_window",  glb_pkg::LINE_W'(want.col_window),
                          glb_pkg::LINE_W'(got.col_window));
            compare_field("diag_window", glb_pkg::LINE_W'(want.diag_window),
                          glb_pkg::LINE_W'(got.diag_window));
            compare_field("anti_window", glb_pkg::LINE_W'(want.anti_window),
                          glb_pkg::LINE_W'(got.anti_window));
            compare_field("error",       glb_pkg::LINE_W'(want.error),
                          glb_pkg::LINE_W'(got.error));
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic [glb_pkg::FUNC_W-1:0]    i_func;
    logic [glb_pkg::COORD_W-1:0]   i_row;
    logic [glb_pkg::COORD_W-1:0]   i_col;
    logic [glb_pkg::CELL_W-1:0]    i_cell_code;
    logic                          o_strobe;
    logic [glb_pkg::CELL_W-1:0]    o_cell_value;
    logic [glb_pkg::LINE_W-1:0]    o_row_line;
    logic [glb_pkg::LINE_W-1:0]    o_col_line;
    logic [glb_pkg::LINE_W-1:0]    o_diag_line;
    logic [glb_pkg::LINE_W-1:0]    o_anti_line;
    logic [glb_pkg::WIN_W-1:0]     o_row_window;
    logic [glb_pkg::WIN_W-1:0]     o_col_window;
    logic [glb_pkg::WIN_W-1:0]     o_diag_window;
    logic [glb_pkg::WIN_W-1:0]     o_anti_window;
    logic                          o_error;

    t_board_scoreboard             sb;
    t_board_result                 observed;

    grid_line_bitboard_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_cell_code   (i_cell_code),
        .o_strobe      (o_strobe),
        .o_cell_value  (o_cell_value),
        .o_row_line    (o_row_line),
        .o_col_line    (o_col_line),
        .o_diag_line   (o_diag_line),
        .o_anti_line   (o_anti_line),
        .o_row_window  (o_row_window),
        .o_col_window  (o_col_window),
        .o_diag_window (o_diag_window),
        .o_anti_window (o_anti_window),
        .o_error       (o_error)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Result monitor: strobe and fields sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            observed = '{o_cell_value, o_row_line, o_col_line, o_diag_line,
                         o_anti_line, o_row_window, o_col_window, o_diag_window,
                         o_anti_window, o_error};
            sb.check_result(observed);
        end
    end

    // One command transfer; held until busy is low at a rising edge
    task automatic run_command(input logic [glb_pkg::FUNC_W-1:0] f,
                               input logic [glb_pkg::COORD_W-1:0] r,
                               input logic [glb_pkg::COORD_W-1:0] c,
                               input logic [glb_pkg::CELL_W-1:0] code);
        @(negedge i_clk);
        start       <= 1'b1;
        i_func      <= f;
        i_row       <= r;
        i_col       <= c;
        i_cell_code <= code;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_command(f, r, c, code);
    endtask

    // Sender gap with junk on the fields
    task automatic idle_cycle();
        @(negedge i_clk);
        start       <= 1'b0;
        i_func      <= glb_pkg::FUNC_W'($urandom);
        i_row       <= glb_pkg::COORD_W'($urandom);
        i_col       <= glb_pkg::COORD_W'($urandom);
        i_cell_code <= glb_pkg::CELL_W'($urandom);
    endtask

    task automatic wait_until_drained();
        idle_cycle();
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    // Mostly on-board coordinates, now and then anything the field allows
    function automatic logic [glb_pkg::COORD_W-1:0] pick_coord();
        if ($urandom_range(0, 99) < 5)
            return glb_pkg::COORD_W'($urandom);
        return glb_pkg::COORD_W'($urandom_range(0, glb_pkg::BOARD_SIZE - 1));
    endfunction

    // Stimulus
    initial begin : stimulus
        int                          sel;
        logic [glb_pkg::CELL_W-1:0]  code;
        bit                          quiet;
        sb          = new();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_func      = glb_pkg::FN_CLEAR;
        i_row       = '0;
        i_col       = '0;
        i_cell_code = glb_pkg::CODE_OFF;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: board after reset, corners, refused and off-board writes
        run_command(glb_pkg::FN_READ, 4'd0,  4'd0,  glb_pkg::CODE_OFF);
        run_command(glb_pkg::FN_READ, 4'd14, 4'd14, glb_pkg::CODE_OFF);
        run_command(glb_pkg::FN_READ, 4'd0,  4'd14, glb_pkg::CODE_OFF);
        run_command(glb_pkg::FN_READ, 4'd14, 4'd0,  glb_pkg::CODE_OFF);
        run_command(glb_pkg::FN_SET,  4'd0,  4'd0,  2'd1);
        run_command(glb_pkg::FN_SET,  4'd14, 4'd14, 2'd2);
        run_command(glb_pkg::FN_SET,  4'd0,  4'd14, CODE_FULL);
        run_command(glb_pkg::FN_SET,  4'd14, 4'd0,  2'd1);
        run_command(glb_pkg::FN_SET,  4'd7,  4'd7,  glb_pkg::CODE_OFF);
        run_command(glb_pkg::FN_SET,  4'd15, 4'd3,  2'd2);
        run_command(glb_pkg::FN_SET,  4'd3,  4'd15, 2'd1);
        run_command(glb_pkg::FN_SET,  4'd15, 4'd15, glb_pkg::CODE_OFF);
        run_command(glb_pkg::FN_SET,  4'd6,  4'd8,  2'd2);
        run_command(glb_pkg::FN_READ, 4'd0,  4'd0,  CODE_FULL);
        run_command(glb_pkg::FN_READ, 4'd14, 4'd14, glb_pkg::CODE_OFF);
        run_command(glb_pkg::FN_READ, 4'd0,  4'd14, glb_pkg::CODE_OFF);
        run_command(glb_pkg::FN_READ, 4'd14, 4'd0,  glb_pkg::CODE_OFF);
        run_command(glb_pkg::FN_READ, 4'd7,  4'd7,  glb_pkg::CODE_OFF);
        run_command(glb_pkg::FN_READ, 4'd6,  4'd8,  glb_pkg::CODE_OFF);
        run_command(glb_pkg::FN_READ, 4'd15, 4'd15, glb_pkg::CODE_OFF);
        run_command(glb_pkg::FN_READ, 4'd3,  4'd15, glb_pkg::CODE_OFF);
        run_command(FN_NONE,          4'd15, 4'd15, CODE_FULL);
        run_command(glb_pkg::FN_CLEAR, 4'd15, 4'd15, CODE_FULL);
        run_command(glb_pkg::FN_READ, 4'd0,  4'd0,  glb_pkg::CODE_OFF);

        // Random: mostly sets and reads on a live board, rare clears and junk
        for (int n = 0; n < 650; n++) begin
            quiet = (n >= 200 && n < 350);
            if (!quiet && $urandom_range(0, 99) < 6)
                repeat ($urandom_range(1, 3)) idle_cycle();
            if (n == 450)
                wait_until_drained();
            sel  = $urandom_range(0, 99);
            code = ($urandom_range(0, 99) < 5) ? glb_pkg::CODE_OFF
                                               : glb_pkg::CELL_W'($urandom_range(1, 3));
            if (sel < 2)
                run_command(glb_pkg::FN_CLEAR, pick_coord(), pick_coord(),
                            glb_pkg::CELL_W'($urandom));
            else if (sel < 5)
                run_command(FN_NONE, pick_coord(), pick_coord(), glb_pkg::CELL_W'($urandom));
            else if (sel < 55)
                run_command(glb_pkg::FN_SET, pick_coord(), pick_coord(), code);
            else
                run_command(glb_pkg::FN_READ, pick_coord(), pick_coord(),
                            glb_pkg::CELL_W'($urandom));
        end

        // Drain, then allow for the pipeline latency
        wait_until_drained();
        repeat (4) @(posedge i_clk);
        if (sb.expected_q.size() != 0) begin
            $error("%0d results never arrived", sb.expected_q.size());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
rtl/glb_pkg.sv
rtl/glb_front.sv
rtl/glb_cmd_fifo.sv
rtl/glb_back.sv
rtl/grid_line_bitboard_top.sv
tb/tb.sv
